/* design/dba_pkg.sv */
// Package for the downlink batch admission block.
// Holds the shared types, register indexes, verdict and counter codes, and reset values.
// No dependencies.
package dba_pkg;

   localparam int NUM_ENTITIES_DEF = 64;
   localparam int NUM_CLASSES_DEF = 2;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 144;
   localparam int NUM_STATS = 16;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_BYTES = 3'd0,
      CSR_MAX_BYTES = 3'd1,
      CSR_MAX_PKTS  = 3'd2,
      CSR_COOLDOWN  = 3'd3,
      CSR_SHIFT     = 3'd4,
      CSR_HEADER    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      V_FORWARDED  = 4'd0,
      V_NO_BATCH   = 4'd1,
      V_EMPTY      = 4'd2,
      V_COOLDOWN   = 4'd3,
      V_UNMAPPED   = 4'd4,
      V_QUERY_FAIL = 4'd5,
      V_NO_FIT     = 4'd6,
      V_TARGET     = 4'd7,
      V_CAP        = 4'd8,
      V_REFUSED    = 4'd9
   } verdict_type;

   localparam int STAT_FWD_PKTS    = 0;
   localparam int STAT_FWD_BYTES   = 1;
   localparam int STAT_PEEKS       = 2;
   localparam int STAT_COOL_SKIPS  = 3;
   localparam int STAT_UNMAPPED    = 4;
   localparam int STAT_QUERY_FAIL  = 5;
   localparam int STAT_ROOM_POS    = 6;
   localparam int STAT_NOFIT_ZERO  = 7;
   localparam int STAT_NOFIT_POS   = 8;
   localparam int STAT_UNUSED_ROOM = 9;
   localparam int STAT_BLOCKED     = 10;
   localparam int STAT_OPENINGS    = 11;
   localparam int STAT_MULTI       = 12;
   localparam int STAT_PKT_LIMIT   = 13;
   localparam int STAT_CAP         = 14;
   localparam int STAT_TARGET      = 15;

   localparam logic [23:0] MIN_BYTES_RST = 24'd65536;
   localparam logic [23:0] MAX_BYTES_RST = 24'd262144;
   localparam logic [7:0]  MAX_PKTS_RST  = 8'd128;
   localparam logic [31:0] COOLDOWN_RST  = 32'd1000000;
   localparam logic [2:0]  SHIFT_RST     = 3'd2;
   localparam logic [3:0]  HEADER_RST    = 4'd1;

   typedef struct packed {
      logic [23:0] min_bytes;
      logic [23:0] max_bytes;
      logic [7:0]  max_pkts;
      logic [31:0] cooldown;
      logic [2:0]  shift;
      logic [3:0]  header;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic        new_batch;
      logic [5:0]  entity_index;
      logic        class_index;
      logic        head_present;
      logic        mapping_valid;
      logic        query_ok;
      logic [31:0] room_bytes;
      logic [15:0] payload_bytes;
      logic [63:0] time_ns;
      logic        send_ok;
      logic [3:0]  counter_select;
   } req_item_type;

   typedef struct packed {
      verdict_type verdict;
      logic        forwarded;
      logic [16:0] packet_bytes;
      logic [7:0]  batch_packets;
      logic [23:0] batch_bytes_out;
      logic        batch_end;
      logic [23:0] target_bytes;
      logic [63:0] counter_value;
   } rsp_item_type;

   typedef struct packed {
      logic        open;
      logic [7:0]  packets;
      logic [23:0] bytes;
   } batch_state_type;

   typedef struct packed {
      logic        fwd_pkt;
      logic [16:0] fwd_bytes;
      logic        peek;
      logic        cool_skip;
      logic        unmapped;
      logic        query_fail;
      logic        room_pos;
      logic        nofit_zero;
      logic        nofit_pos;
      logic [31:0] unused_room;
      logic        blocked;
      logic        opening;
      logic [1:0]  multi;
      logic [1:0]  pkt_limit;
      logic        cap;
      logic        target;
   } stat_inc_type;

   typedef struct packed {
      logic        en;
      logic [63:0] value;
   } deadline_wr_type;

endpackage

/* design/dba_cooldown_table.sv */
// Cooldown deadline memory, one entry per entity and class, with per-entry valid bits.
// Registered read with write-to-read bypass for back-to-back access. Depends on dba_pkg.
module dba_cooldown_table
   import dba_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_ENTITIES_DEF * NUM_CLASSES_DEF,
   parameter int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [SLOT_W-1:0] wr_slot,
   input  deadline_wr_type   wr,
   output logic [63:0]       rd_deadline
);

   logic [63:0]          deadline_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [63:0]          rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         deadline_mem[wr_slot] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr_slot == rd_slot)) begin
            rd_ff <= wr.value;
         end else if (valid_ff[rd_slot]) begin
            rd_ff <= deadline_mem[rd_slot];
         end else begin
            rd_ff <= '0;
         end
      end
   end

   assign rd_deadline = rd_ff;

endmodule

/* design/dba_stats.sv */
// Sixteen wrapping 64-bit statistics counters with a selected read.
// Depends on dba_pkg.
module dba_stats
   import dba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         upd_en,
   input  stat_inc_type inc,
   input  logic [3:0]   sel,
   output logic [63:0]  value
);

   logic [63:0] cnt_ff [NUM_STATS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STATS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (upd_en) begin
         cnt_ff[STAT_FWD_PKTS]    <= cnt_ff[STAT_FWD_PKTS] + 64'(inc.fwd_pkt);
         cnt_ff[STAT_FWD_BYTES]   <= cnt_ff[STAT_FWD_BYTES] + 64'(inc.fwd_bytes);
         cnt_ff[STAT_PEEKS]       <= cnt_ff[STAT_PEEKS] + 64'(inc.peek);
         cnt_ff[STAT_COOL_SKIPS]  <= cnt_ff[STAT_COOL_SKIPS] + 64'(inc.cool_skip);
         cnt_ff[STAT_UNMAPPED]    <= cnt_ff[STAT_UNMAPPED] + 64'(inc.unmapped);
         cnt_ff[STAT_QUERY_FAIL]  <= cnt_ff[STAT_QUERY_FAIL] + 64'(inc.query_fail);
         cnt_ff[STAT_ROOM_POS]    <= cnt_ff[STAT_ROOM_POS] + 64'(inc.room_pos);
         cnt_ff[STAT_NOFIT_ZERO]  <= cnt_ff[STAT_NOFIT_ZERO] + 64'(inc.nofit_zero);
         cnt_ff[STAT_NOFIT_POS]   <= cnt_ff[STAT_NOFIT_POS] + 64'(inc.nofit_pos);
         cnt_ff[STAT_UNUSED_ROOM] <= cnt_ff[STAT_UNUSED_ROOM] + 64'(inc.unused_room);
         cnt_ff[STAT_BLOCKED]     <= cnt_ff[STAT_BLOCKED] + 64'(inc.blocked);
         cnt_ff[STAT_OPENINGS]    <= cnt_ff[STAT_OPENINGS] + 64'(inc.opening);
         cnt_ff[STAT_MULTI]       <= cnt_ff[STAT_MULTI] + 64'(inc.multi);
         cnt_ff[STAT_PKT_LIMIT]   <= cnt_ff[STAT_PKT_LIMIT] + 64'(inc.pkt_limit);
         cnt_ff[STAT_CAP]         <= cnt_ff[STAT_CAP] + 64'(inc.cap);
         cnt_ff[STAT_TARGET]      <= cnt_ff[STAT_TARGET] + 64'(inc.target);
      end
   end

   assign value = cnt_ff[sel];

endmodule

/* design/dba_decide.sv */
// Admission decision or counter read for one registered item: verdict, batch update, counter
// increments and cooldown deadline write. Depends on dba_pkg.
module dba_decide
   import dba_pkg::*;
(
   input  req_item_type    item,
   input  cfg_type         cfg,
   input  batch_state_type batch,
   input  logic            has_slot,
   input  logic [63:0]     deadline,
   input  logic [63:0]     counter_value,
   output rsp_item_type    rsp,
   output batch_state_type batch_nxt,
   output stat_inc_type    stat_inc,
   output deadline_wr_type dl_wr
);

   logic [16:0] pkt;
   logic [31:0] shifted;
   logic [31:0] raised;
   logic [23:0] tgt;
   logic        degenerate;
   logic        cool;
   logic        open_w;
   logic [7:0]  pkts_w;
   logic [23:0] bytes_w;
   logic [24:0] sum;
   logic [1:0]  multi;
   logic [1:0]  lim;
   verdict_type verdict;

   always_comb begin
      rsp = '0;
      batch_nxt = batch;
      stat_inc = '0;
      dl_wr = '0;
      pkt = 17'(item.payload_bytes) + 17'(cfg.header);
      shifted = item.room_bytes >> cfg.shift;
      raised = (shifted < 32'(cfg.min_bytes)) ? 32'(cfg.min_bytes) : shifted;
      tgt = (raised > 32'(cfg.max_bytes)) ? cfg.max_bytes : raised[23:0];
      degenerate = (cfg.max_pkts == '0) || (cfg.max_bytes == '0);
      cool = has_slot && (deadline > item.time_ns);
      open_w = batch.open;
      pkts_w = batch.packets;
      bytes_w = batch.bytes;
      sum = '0;
      multi = '0;
      lim = '0;
      verdict = V_FORWARDED;

      if (item.opcode == OP_READ) begin
         rsp.counter_value = counter_value;
      end else begin
         if (item.new_batch) begin
            if (open_w) begin
               multi = multi + 2'(pkts_w > 8'd1);
               lim = lim + 2'(pkts_w == cfg.max_pkts);
            end
            stat_inc.opening = 1'b1;
            open_w = 1'b1;
            pkts_w = '0;
            bytes_w = '0;
         end

         if (item.new_batch && degenerate) begin
            lim = lim + 2'(cfg.max_pkts == '0);
            open_w = 1'b0;
            rsp.verdict = V_NO_BATCH;
            rsp.batch_end = 1'b1;
         end else begin
            sum = 25'(bytes_w) + 25'(pkt);
            if (!open_w) begin
               verdict = V_NO_BATCH;
            end else if (!item.head_present) begin
               verdict = V_EMPTY;
            end else begin
               stat_inc.peek = 1'b1;
               rsp.packet_bytes = pkt;
               if (cool) begin
                  stat_inc.cool_skip = 1'b1;
                  verdict = V_COOLDOWN;
               end else if (!item.mapping_valid) begin
                  stat_inc.unmapped = 1'b1;
                  verdict = V_UNMAPPED;
               end else if (!item.query_ok) begin
                  stat_inc.query_fail = 1'b1;
                  verdict = V_QUERY_FAIL;
               end else begin
                  stat_inc.room_pos = (item.room_bytes != '0);
                  rsp.target_bytes = tgt;
                  if (32'(pkt) > item.room_bytes) begin
                     if (item.room_bytes == '0) begin
                        stat_inc.nofit_zero = 1'b1;
                     end else begin
                        stat_inc.nofit_pos = 1'b1;
                        stat_inc.unused_room = item.room_bytes;
                     end
                     dl_wr.en = has_slot;
                     dl_wr.value = item.time_ns + 64'(cfg.cooldown);
                     stat_inc.blocked = 1'b1;
                     verdict = V_NO_FIT;
                  end else if ((pkts_w != '0) && (sum > 25'(tgt))) begin
                     stat_inc.target = 1'b1;
                     verdict = V_TARGET;
                  end else if (sum > 25'(cfg.max_bytes)) begin
                     stat_inc.cap = 1'b1;
                     verdict = V_CAP;
                  end else if (!item.send_ok) begin
                     verdict = V_REFUSED;
                  end else begin
                     dl_wr.en = has_slot;
                     dl_wr.value = '0;
                     stat_inc.fwd_pkt = 1'b1;
                     stat_inc.fwd_bytes = pkt;
                     pkts_w = pkts_w + 8'd1;
                     bytes_w = sum[23:0];
                     rsp.forwarded = 1'b1;
                     verdict = V_FORWARDED;
                  end
               end
            end

            if (open_w) begin
               if ((verdict != V_FORWARDED) || (pkts_w >= cfg.max_pkts)
                   || (bytes_w >= cfg.max_bytes)) begin
                  multi = multi + 2'(pkts_w > 8'd1);
                  lim = lim + 2'(pkts_w == cfg.max_pkts);
                  open_w = 1'b0;
               end
            end

            rsp.verdict = verdict;
            rsp.batch_packets = pkts_w;
            rsp.batch_bytes_out = bytes_w;
            rsp.batch_end = !open_w;
         end

         stat_inc.multi = multi;
         stat_inc.pkt_limit = lim;
         batch_nxt.open = open_w;
         batch_nxt.packets = pkts_w;
         batch_nxt.bytes = bytes_w;
      end
   end

endmodule

/* design/downlink_batch_admission.sv */
// Downlink batch admission: decides per head-of-queue offer whether to forward the packet.
// The request is registered in the input register and its result in the result register.
// Throughput: one request per cycle while responses are taken; the cooldown memory read is
// issued at transfer and bypassed from the write of the item ahead of it.
// Reset: clears batch state, statistics counters and cooldown valid bits, and sets the
// configuration to defaults; no clearing pass.
module downlink_batch_admission
   import dba_pkg::*;
#(
   parameter int NUM_ENTITIES = NUM_ENTITIES_DEF,
   parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // new_batch, entity_index, class_index, head_present, mapping_valid, query_ok,
   // room_bytes, payload_bytes, time_ns, send_ok, counter_select
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // verdict, forwarded, packet_bytes, batch_packets, batch_bytes_out, target_bytes,
   // counter_value, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // batch_end
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NUM_SLOTS = NUM_ENTITIES * NUM_CLASSES;
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   cfg_type         cfg_ff;
   req_item_type    req_item;
   req_item_type    s1_item_ff;
   logic            s1_valid_ff;
   rsp_item_type    rsp_ff;
   rsp_item_type    rsp_in;
   logic            rsp_valid_ff;
   batch_state_type batch_ff;
   batch_state_type batch_in;
   stat_inc_type    stat_inc;
   deadline_wr_type dl_wr;
   deadline_wr_type tbl_wr;
   logic [63:0]     deadline;
   logic [63:0]     counter_value;
   logic            advance;
   logic            accept;
   logic [31:0]     in_slot_full;
   logic [31:0]     s1_slot_full;
   logic            s1_has_slot;

   always_comb begin
      req_item.opcode = req_tuser;
      req_item.new_batch = req_tdata[0];
      req_item.entity_index = req_tdata[6:1];
      req_item.class_index = req_tdata[7];
      req_item.head_present = req_tdata[8];
      req_item.mapping_valid = req_tdata[9];
      req_item.query_ok = req_tdata[10];
      req_item.room_bytes = req_tdata[42:11];
      req_item.payload_bytes = req_tdata[58:43];
      req_item.time_ns = req_tdata[122:59];
      req_item.send_ok = req_tdata[123];
      req_item.counter_select = req_tdata[127:124];
   end

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept = req_tvalid && req_tready;

   assign in_slot_full = 32'(req_item.entity_index) * 32'(NUM_CLASSES)
                         + 32'(req_item.class_index);
   assign s1_slot_full = 32'(s1_item_ff.entity_index) * 32'(NUM_CLASSES)
                         + 32'(s1_item_ff.class_index);
   assign s1_has_slot = (32'(s1_item_ff.entity_index) < 32'(NUM_ENTITIES))
                        && (32'(s1_item_ff.class_index) < 32'(NUM_CLASSES));

   always_comb begin
      tbl_wr = dl_wr;
      tbl_wr.en = dl_wr.en && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bytes <= MIN_BYTES_RST;
         cfg_ff.max_bytes <= MAX_BYTES_RST;
         cfg_ff.max_pkts <= MAX_PKTS_RST;
         cfg_ff.cooldown <= COOLDOWN_RST;
         cfg_ff.shift <= SHIFT_RST;
         cfg_ff.header <= HEADER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_BYTES: cfg_ff.min_bytes <= csr_wdata[23:0];
            CSR_MAX_BYTES: cfg_ff.max_bytes <= csr_wdata[23:0];
            CSR_MAX_PKTS:  cfg_ff.max_pkts <= csr_wdata[7:0];
            CSR_COOLDOWN:  cfg_ff.cooldown <= csr_wdata[31:0];
            CSR_SHIFT:     cfg_ff.shift <= csr_wdata[2:0];
            CSR_HEADER:    cfg_ff.header <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= '0;
      end else if (advance) begin
         batch_ff <= batch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   dba_cooldown_table #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_slot     (in_slot_full[SLOT_W-1:0]),
      .wr_slot     (s1_slot_full[SLOT_W-1:0]),
      .wr          (tbl_wr),
      .rd_deadline (deadline)
   );

   dba_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .upd_en (advance),
      .inc    (stat_inc),
      .sel    (s1_item_ff.counter_select),
      .value  (counter_value)
   );

   dba_decide u_decide (
      .item          (s1_item_ff),
      .cfg           (cfg_ff),
      .batch         (batch_ff),
      .has_slot      (s1_has_slot),
      .deadline      (deadline),
      .counter_value (counter_value),
      .rsp           (rsp_in),
      .batch_nxt     (batch_in),
      .stat_inc      (stat_inc),
      .dl_wr         (dl_wr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = rsp_ff.batch_end;
   assign rsp_tdata = {2'b00, rsp_ff.counter_value, rsp_ff.target_bytes,
                       rsp_ff.batch_bytes_out, rsp_ff.batch_packets, rsp_ff.packet_bytes,
                       rsp_ff.forwarded, rsp_ff.verdict};

endmodule
